// ----- rtl/imcol_pkg.sv -----
package imcol_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 7;
    localparam int INDEX_W    = 12;
    localparam int VALUE_W    = 32;
    // Widest source index: (63*127 + 15*63 + 15)*127 + 15*63 + 15 needs 21 bits.
    localparam int SRC_W      = 21;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNELS    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_ROWS  = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_IMAGE_COLS  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_ROWS = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_KERNEL_COLS = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_ROWS    = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_OUT_COLS    = 3'd6;
    localparam logic [CFG_IDX_W-1:0] REG_STRIDE      = 3'd7;

    localparam logic ACT_WRITE = 1'b0;
    localparam logic ACT_READ  = 1'b1;

    typedef struct packed {
        logic accept_write;
        logic accept_read;
        logic stage2_en;
        logic read_en;
        logic load_out;
    } imcol_cmd_t;

    typedef struct packed {
        logic out_free;
    } imcol_status_t;

endpackage

// ----- rtl/imcol_ctrl.sv -----
module imcol_ctrl (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    input  logic                     s_action,
    output logic                     s_ready,
    input  imcol_pkg::imcol_status_t status,
    output imcol_pkg::imcol_cmd_t    cmd
);
    import imcol_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_MUL  = 2'd1;
    localparam logic [1:0] ST_READ = 2'd2;
    localparam logic [1:0] ST_LOAD = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        cmd.accept_write = s_valid && s_ready && (s_action == ACT_WRITE);
        cmd.accept_read  = s_valid && s_ready && (s_action == ACT_READ);
        cmd.stage2_en    = (state_reg == ST_MUL);
        cmd.read_en      = (state_reg == ST_READ);
        cmd.load_out     = (state_reg == ST_LOAD) && status.out_free;
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (cmd.accept_read) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:  state_next = ST_READ;
            ST_READ: state_next = ST_LOAD;
            ST_LOAD: begin
                // The result waits here until the output register is free.
                if (status.out_free) begin
                    state_next = ST_IDLE;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

`ifndef NO_ASSERTIONS
    a_read_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.accept_read |=> (state_reg == ST_MUL))
        else $error("read beat did not start the address pipeline");
    a_mul_to_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_MUL) |=> (state_reg == ST_READ))
        else $error("address stage did not advance to the store read");
    a_load_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_LOAD && !status.out_free) |=> (state_reg == ST_LOAD))
        else $error("pending result left the load state while output was full");
`endif

endmodule

// ----- rtl/imcol_dp.sv -----
module imcol_dp #(
    parameter int STORE_DEPTH = 4096,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               cfg_we,
    input  logic [imcol_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [imcol_pkg::CFG_DATA_W-1:0]   cfg_wdata,
    input  logic [imcol_pkg::INDEX_W-1:0]      s_write_index,
    input  logic [imcol_pkg::VALUE_W-1:0]      s_write_value,
    output logic [imcol_pkg::VALUE_W-1:0]      m_column_value,
    output logic                               m_out_of_range,
    output logic                               m_last,
    output logic                               m_valid,
    input  logic                               m_ready,
    input  imcol_pkg::imcol_cmd_t              cmd,
    output imcol_pkg::imcol_status_t           status
);
    import imcol_pkg::*;

    localparam int ADDR_W = $clog2(STORE_DEPTH);
    // Only the low 32 bits of a word ever reach the result.
    localparam int KEEP_W = (WORD_WIDTH < VALUE_W) ? WORD_WIDTH : VALUE_W;

    function automatic logic [6:0] bound_lim(input logic [6:0] v, input logic [6:0] maxv);
        logic [6:0] r;
        if (v == 7'd0) begin
            r = 7'd1;
        end else if (v > maxv) begin
            r = maxv;
        end else begin
            r = v;
        end
        return r;
    endfunction

    // Configuration registers.
    logic [6:0] channels_reg, image_rows_reg, image_cols_reg, out_rows_reg, out_cols_reg;
    logic [4:0] kernel_rows_reg, kernel_cols_reg;
    logic [3:0] stride_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            channels_reg    <= 7'd1;
            image_rows_reg  <= 7'd1;
            image_cols_reg  <= 7'd1;
            kernel_rows_reg <= 5'd1;
            kernel_cols_reg <= 5'd1;
            out_rows_reg    <= 7'd1;
            out_cols_reg    <= 7'd1;
            stride_reg      <= 4'd1;
        end else if (cfg_we) begin
            unique case (cfg_index)
                REG_CHANNELS:    channels_reg    <= cfg_wdata;
                REG_IMAGE_ROWS:  image_rows_reg  <= cfg_wdata;
                REG_IMAGE_COLS:  image_cols_reg  <= cfg_wdata;
                REG_KERNEL_ROWS: kernel_rows_reg <= cfg_wdata[4:0];
                REG_KERNEL_COLS: kernel_cols_reg <= cfg_wdata[4:0];
                REG_OUT_ROWS:    out_rows_reg    <= cfg_wdata;
                REG_OUT_COLS:    out_cols_reg    <= cfg_wdata;
                REG_STRIDE:      stride_reg      <= cfg_wdata[3:0];
            endcase
        end
    end

    // Scan counters, innermost first: output column, output row, kernel column,
    // kernel row, channel.
    logic [5:0] ocol_reg, orow_reg, chan_reg;
    logic [3:0] kcol_reg, krow_reg;
    logic [5:0] ocol_next, orow_next, chan_next;
    logic [3:0] kcol_next, krow_next;
    logic [6:0] oc_lim, or_lim, ch_lim;
    logic [4:0] kc_lim, kr_lim;
    logic       oc_wrap, or_wrap, kc_wrap, kr_wrap, ch_wrap;
    logic       last_next;

    always_comb begin
        oc_lim = bound_lim(out_cols_reg, 7'd64);
        or_lim = bound_lim(out_rows_reg, 7'd64);
        ch_lim = bound_lim(channels_reg, 7'd64);
        kc_lim = 5'(bound_lim(7'(kernel_cols_reg), 7'd16));
        kr_lim = 5'(bound_lim(7'(kernel_rows_reg), 7'd16));

        // A counter at or past its bound minus one counts as finished.
        oc_wrap = (7'(ocol_reg) + 7'd1) >= oc_lim;
        or_wrap = (7'(orow_reg) + 7'd1) >= or_lim;
        kc_wrap = (5'(kcol_reg) + 5'd1) >= kc_lim;
        kr_wrap = (5'(krow_reg) + 5'd1) >= kr_lim;
        ch_wrap = (7'(chan_reg) + 7'd1) >= ch_lim;

        ocol_next = oc_wrap ? 6'd0 : ocol_reg + 6'd1;
        orow_next = orow_reg;
        kcol_next = kcol_reg;
        krow_next = krow_reg;
        chan_next = chan_reg;
        if (oc_wrap) begin
            orow_next = or_wrap ? 6'd0 : orow_reg + 6'd1;
        end
        if (oc_wrap && or_wrap) begin
            kcol_next = kc_wrap ? 4'd0 : kcol_reg + 4'd1;
        end
        if (oc_wrap && or_wrap && kc_wrap) begin
            krow_next = kr_wrap ? 4'd0 : krow_reg + 4'd1;
        end
        if (oc_wrap && or_wrap && kc_wrap && kr_wrap) begin
            chan_next = ch_wrap ? 6'd0 : chan_reg + 6'd1;
        end
        last_next = oc_wrap && or_wrap && kc_wrap && kr_wrap && ch_wrap;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ocol_reg <= 6'd0;
            orow_reg <= 6'd0;
            kcol_reg <= 4'd0;
            krow_reg <= 4'd0;
            chan_reg <= 6'd0;
        end else if (cmd.accept_read) begin
            ocol_reg <= ocol_next;
            orow_reg <= orow_next;
            kcol_reg <= kcol_next;
            krow_reg <= krow_next;
            chan_reg <= chan_next;
        end
    end

    // Address pipeline. The first stage forms the three small products from
    // the counters as they stand when the read beat is taken; the second
    // scales the row index by the image width.
    logic [12:0]      chan_rows_reg;
    logic [9:0]       row_off_reg, col_off_reg;
    logic             last1_reg, last2_reg, last3_reg;
    logic [13:0]      row_idx;
    logic [SRC_W-1:0] src_next, src_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept_read) begin
            chan_rows_reg <= 13'(chan_reg) * 13'(image_rows_reg);
            row_off_reg   <= 10'(stride_reg) * 10'(orow_reg) + 10'(krow_reg);
            col_off_reg   <= 10'(stride_reg) * 10'(ocol_reg) + 10'(kcol_reg);
            last1_reg     <= last_next;
        end
    end

    assign row_idx  = 14'(chan_rows_reg) + 14'(row_off_reg);
    assign src_next = SRC_W'(row_idx) * SRC_W'(image_cols_reg) + SRC_W'(col_off_reg);

    always_ff @(posedge aclk) begin
        if (cmd.stage2_en) begin
            src_reg   <= src_next;
            last2_reg <= last1_reg;
        end
    end

    // Image store.
    logic [KEEP_W-1:0] store_mem [STORE_DEPTH];
    logic [KEEP_W-1:0] rdata_reg;
    logic              oor_reg;

    always_ff @(posedge aclk) begin
        if (cmd.accept_write && (32'(s_write_index) < STORE_DEPTH)) begin
            store_mem[ADDR_W'(s_write_index)] <= KEEP_W'(s_write_value);
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.read_en) begin
            rdata_reg <= store_mem[src_reg[ADDR_W-1:0]];
            oor_reg   <= 32'(src_reg) >= STORE_DEPTH;
            last3_reg <= last2_reg;
        end
    end

    // Output register.
    logic               m_valid_reg;
    logic [VALUE_W-1:0] value_reg;
    logic               oor_out_reg, last_out_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            value_reg    <= oor_reg ? '0 : VALUE_W'(rdata_reg);
            oor_out_reg  <= oor_reg;
            last_out_reg <= last3_reg;
        end
    end

    assign m_valid         = m_valid_reg;
    assign m_column_value  = value_reg;
    assign m_out_of_range  = oor_out_reg;
    assign m_last          = last_out_reg;
    assign status.out_free = !m_valid_reg || m_ready;

`ifndef NO_ASSERTIONS
    a_load_sets_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load_out |=> m_valid)
        else $error("loaded result is not presented");
    a_oor_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_out_of_range) |-> (m_column_value == '0))
        else $error("out-of-range beat carries a nonzero word");
    a_last_wraps: assert property (@(posedge aclk) disable iff (!aresetn)
        (cmd.accept_read && last_next) |=>
            (ocol_reg == 6'd0 && orow_reg == 6'd0 && kcol_reg == 4'd0 &&
             krow_reg == 4'd0 && chan_reg == 6'd0))
        else $error("counters did not wrap after the final element");
`endif

endmodule

// ----- rtl/im2col_column_reorder.sv -----
// im2col column reorder. An input beat with action 0 writes one word into the
// image store at write_index (indexes at or beyond STORE_DEPTH are dropped); a
// beat with action 1 returns the next element of the im2col column matrix,
// scanning output column fastest, then output row, kernel column, kernel row
// and channel. The word comes from store index
// (channel*image_rows + stride*orow + krow)*image_cols + stride*ocol + kcol;
// an index at or beyond STORE_DEPTH returns zero with out_of_range set, and
// last marks the final element, after which the scan starts over. For a read
// beat, the accepting edge forms the channel and offset products; then follow
// the multiply by the image width, the registered store read and the output
// load. Input ready stays low from an accepted read until its result is
// loaded, so no new beat is taken while a read is in flight, and the load
// waits while the previous result has not been taken and the output register
// is full. The store has no reset; reading a word that was never written gives
// an arbitrary value. The user must write registers only while the block is
// idle; the block itself does not enforce this.
module im2col_column_reorder #(
    parameter int STORE_DEPTH = 4096,
    parameter int WORD_WIDTH  = 32
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [imcol_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [imcol_pkg::CFG_DATA_W-1:0]  cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic                              s_action,
    input  logic [imcol_pkg::INDEX_W-1:0]     s_write_index,
    input  logic [imcol_pkg::VALUE_W-1:0]     s_write_value,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic [imcol_pkg::VALUE_W-1:0]     m_column_value,
    output logic                              m_out_of_range,
    output logic                              m_last
);
    import imcol_pkg::*;

    imcol_cmd_t    cmd;
    imcol_status_t status;

    imcol_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_action (s_action),
        .s_ready  (s_ready),
        .status   (status),
        .cmd      (cmd)
    );

    imcol_dp #(
        .STORE_DEPTH (STORE_DEPTH),
        .WORD_WIDTH  (WORD_WIDTH)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_write_index  (s_write_index),
        .s_write_value  (s_write_value),
        .m_column_value (m_column_value),
        .m_out_of_range (m_out_of_range),
        .m_last         (m_last),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .cmd            (cmd),
        .status         (status)
    );

endmodule

// ----- test/im2col_column_checker.sv -----
`timescale 1ns / 1ps

module im2col_column_checker (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             cfg_we,
    input  logic [imcol_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [imcol_pkg::CFG_DATA_W-1:0] cfg_wdata,
    input  logic                             s_valid,
    input  logic                             s_ready,
    input  logic                             s_action,
    input  logic [imcol_pkg::INDEX_W-1:0]    s_write_index,
    input  logic [imcol_pkg::VALUE_W-1:0]    s_write_value,
    input  logic                             m_valid,
    input  logic                             m_ready,
    input  logic [imcol_pkg::VALUE_W-1:0]    m_column_value,
    input  logic                             m_out_of_range,
    input  logic                             m_last,
    output int                               fail_count,
    output int                               pending_count,
    output int                               columns_checked,
    output int                               last_count,
    output int                               oor_count
);
    import imcol_pkg::*;

    localparam int STORE_WORDS = 4096;

    // Scan levels, innermost first.
    localparam int LVL_OCOL = 0;
    localparam int LVL_OROW = 1;
    localparam int LVL_KCOL = 2;
    localparam int LVL_KROW = 3;
    localparam int LVL_CHAN = 4;
    localparam int LEVELS   = 5;

    typedef struct packed {
        logic [VALUE_W-1:0] value;
        logic               oor;
        logic               last;
    } column_beat_t;

    logic [VALUE_W-1:0] image_copy [0:STORE_WORDS-1];

    logic [6:0] channels_r;
    logic [6:0] image_rows_r;
    logic [6:0] image_cols_r;
    logic [4:0] kernel_rows_r;
    logic [4:0] kernel_cols_r;
    logic [6:0] out_rows_r;
    logic [6:0] out_cols_r;
    logic [3:0] stride_r;

    int unsigned  scan_pos [LEVELS];
    column_beat_t column_fifo [$];

    // A zero bound counts as one, and bounds saturate at the counter range.
    function automatic int unsigned level_limit(int unsigned bound_val, int unsigned ceiling);
        if (bound_val == 0) begin
            return 1;
        end
        return (bound_val > ceiling) ? ceiling : bound_val;
    endfunction

    function automatic column_beat_t next_column();
        column_beat_t beat;
        int unsigned  src;
        int unsigned  lim [LEVELS];
        bit           carry;
        lim[LVL_OCOL] = level_limit(out_cols_r, 64);
        lim[LVL_OROW] = level_limit(out_rows_r, 64);
        lim[LVL_KCOL] = level_limit(kernel_cols_r, 16);
        lim[LVL_KROW] = level_limit(kernel_rows_r, 16);
        lim[LVL_CHAN] = level_limit(channels_r, 64);
        src = (scan_pos[LVL_CHAN] * image_rows_r + stride_r * scan_pos[LVL_OROW]
               + scan_pos[LVL_KROW]) * image_cols_r
              + stride_r * scan_pos[LVL_OCOL] + scan_pos[LVL_KCOL];
        if (src < STORE_WORDS) begin
            beat.value = image_copy[src];
            beat.oor   = 1'b0;
        end else begin
            beat.value = '0;
            beat.oor   = 1'b1;
        end
        // A counter at or past its bound minus one wraps and carries outward.
        carry = 1'b1;
        for (int k = 0; k < LEVELS && carry; k++) begin
            if (scan_pos[k] + 1 >= lim[k]) begin
                scan_pos[k] = 0;
            end else begin
                scan_pos[k] = scan_pos[k] + 1;
                carry = 1'b0;
            end
        end
        beat.last = carry;
        return beat;
    endfunction

    task automatic report_mismatch(input string field, input logic [VALUE_W-1:0] got,
                                   input logic [VALUE_W-1:0] want);
        $display("[%0t] column mismatch on %s: got %h, expected %h", $time, field, got, want);
        fail_count++;
    endtask

    always @(posedge aclk) begin
        column_beat_t want;
        if (!aresetn) begin
            channels_r    = 7'd1;
            image_rows_r  = 7'd1;
            image_cols_r  = 7'd1;
            kernel_rows_r = 5'd1;
            kernel_cols_r = 5'd1;
            out_rows_r    = 7'd1;
            out_cols_r    = 7'd1;
            stride_r      = 4'd1;
            foreach (scan_pos[k]) scan_pos[k] = 0;
            column_fifo.delete();
            fail_count      = 0;
            columns_checked = 0;
            last_count      = 0;
            oor_count       = 0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_CHANNELS:    channels_r    = cfg_wdata;
                    REG_IMAGE_ROWS:  image_rows_r  = cfg_wdata;
                    REG_IMAGE_COLS:  image_cols_r  = cfg_wdata;
                    REG_KERNEL_ROWS: kernel_rows_r = cfg_wdata[4:0];
                    REG_KERNEL_COLS: kernel_cols_r = cfg_wdata[4:0];
                    REG_OUT_ROWS:    out_rows_r    = cfg_wdata;
                    REG_OUT_COLS:    out_cols_r    = cfg_wdata;
                    REG_STRIDE:      stride_r      = cfg_wdata[3:0];
                    default: ;
                endcase
            end
            if (s_valid && s_ready) begin
                if (s_action == ACT_WRITE) begin
                    if (s_write_index < STORE_WORDS) begin
                        image_copy[s_write_index] = s_write_value;
                    end
                end else begin
                    column_fifo.push_back(next_column());
                end
            end
            if (m_valid && m_ready) begin
                if (column_fifo.size() == 0) begin
                    report_mismatch("unexpected beat", m_column_value, '0);
                end else begin
                    want = column_fifo.pop_front();
                    columns_checked++;
                    if (want.last) last_count++;
                    if (want.oor) oor_count++;
                    if (m_column_value !== want.value)
                        report_mismatch("column_value", m_column_value, want.value);
                    if (m_out_of_range !== want.oor)
                        report_mismatch("out_of_range", VALUE_W'(m_out_of_range),
                                        VALUE_W'(want.oor));
                    if (m_last !== want.last)
                        report_mismatch("last", VALUE_W'(m_last), VALUE_W'(want.last));
                end
            end
        end
        pending_count = column_fifo.size();
    end

endmodule

// ----- test/im2col_column_reorder_tb.sv -----
`timescale 1ns / 1ps

module im2col_column_reorder_tb;

    import imcol_pkg::*;

    localparam int STORE_WORDS  = 4096;
    // Only the low part of the store is filled; every read that stays in range
    // is steered into it.
    localparam int FILL_WORDS   = 256;
    localparam int PHASES       = 6;
    localparam int PHASE_BEATS  = 18;
    localparam int DRAIN_CYCLES = 20000;

    logic                  aclk          = 1'b0;
    logic                  aresetn       = 1'b0;
    logic                  cfg_we        = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index     = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata     = '0;
    logic                  s_valid       = 1'b0;
    logic                  s_action      = ACT_WRITE;
    logic [INDEX_W-1:0]    s_write_index = '0;
    logic [VALUE_W-1:0]    s_write_value = '0;
    logic                  m_ready       = 1'b0;
    logic                  s_ready;
    logic                  m_valid;
    logic [VALUE_W-1:0]    m_column_value;
    logic                  m_out_of_range;
    logic                  m_last;

    int fail_count;
    int pending_count;
    int columns_checked;
    int last_count;
    int oor_count;
    int beats_sent;
    int settings_loaded;
    bit steady = 1'b0;

    im2col_column_reorder DUT (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_action      (s_action),
        .s_write_index (s_write_index),
        .s_write_value (s_write_value),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_column_value(m_column_value),
        .m_out_of_range(m_out_of_range),
        .m_last        (m_last)
    );

    im2col_column_checker column_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_action       (s_action),
        .s_write_index  (s_write_index),
        .s_write_value  (s_write_value),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_column_value (m_column_value),
        .m_out_of_range (m_out_of_range),
        .m_last         (m_last),
        .fail_count     (fail_count),
        .pending_count  (pending_count),
        .columns_checked(columns_checked),
        .last_count     (last_count),
        .oor_count      (oor_count)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    always @(negedge aclk) begin
        m_ready <= steady || ($urandom_range(99) >= 24);
    end

    // Called at a falling edge; returns at the falling edge after the beat is taken.
    task automatic send_beat(input logic act, input logic [INDEX_W-1:0] idx,
                             input logic [VALUE_W-1:0] val);
        if (!steady) begin
            while ($urandom_range(99) < 24) begin
                s_valid <= 1'b0;
                @(negedge aclk);
            end
        end
        s_valid       <= 1'b1;
        s_action      <= act;
        s_write_index <= idx;
        s_write_value <= val;
        do @(posedge aclk); while (!s_ready);
        @(negedge aclk);
        beats_sent++;
    endtask

    task automatic read_columns(input int count);
        repeat (count) send_beat(ACT_READ, INDEX_W'($urandom), $urandom);
    endtask

    // Registers may only change once the block has nothing left in flight.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (pending_count != 0) @(negedge aclk);
        repeat (8) @(negedge aclk);
    endtask

    task automatic load_geometry(input logic [6:0] ch, input logic [6:0] rows,
                                 input logic [6:0] cols, input logic [6:0] krows,
                                 input logic [6:0] kcols, input logic [6:0] orows,
                                 input logic [6:0] ocols, input logic [6:0] step);
        logic [CFG_IDX_W-1:0] idx_list [8];
        logic [6:0]           val_list [8];
        idx_list = '{REG_CHANNELS, REG_IMAGE_ROWS, REG_IMAGE_COLS, REG_KERNEL_ROWS,
                     REG_KERNEL_COLS, REG_OUT_ROWS, REG_OUT_COLS, REG_STRIDE};
        val_list = '{ch, rows, cols, krows, kcols, orows, ocols, step};
        wait_idle();
        for (int k = 0; k < 8; k++) begin
            cfg_we    <= 1'b1;
            cfg_index <= idx_list[k];
            cfg_wdata <= val_list[k];
            @(negedge aclk);
        end
        cfg_we <= 1'b0;
        settings_loaded++;
    endtask

    // With every register at one, a single read wraps all counters back to
    // zero, and its index is the sum of the counters, well inside the fill.
    task automatic rewind_scan();
        load_geometry(1, 1, 1, 1, 1, 1, 1, 1);
        read_columns(1);
    endtask

    task automatic random_beat();
        logic [INDEX_W-1:0] idx;
        if ($urandom_range(99) < 70) begin
            read_columns(1);
        end else begin
            // Half the writes land where small geometries read back.
            idx = $urandom_range(1) ? INDEX_W'($urandom_range(FILL_WORDS - 1))
                                    : INDEX_W'($urandom_range(STORE_WORDS - 1));
            send_beat(ACT_WRITE, idx, $urandom);
        end
    endtask

    initial begin
        int drain;
        repeat (7) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Fill the low part of the store; reads never reach past it unless
        // they go beyond the store entirely.
        for (int i = 0; i < FILL_WORDS; i++) begin
            send_beat(ACT_WRITE, INDEX_W'(i), $urandom);
        end

        send_beat(ACT_WRITE, '0, '0);
        send_beat(ACT_WRITE, '1, '1);
        send_beat(ACT_WRITE, 12'd1, 32'h5A5A_A5A5);
        // Reset geometry is a one element matrix: every read is the last one.
        read_columns(2);
        // All registers zero: bounds act as one and every index collapses to zero.
        load_geometry(0, 0, 0, 0, 0, 0, 0, 0);
        read_columns(2);
        // The second channel starts exactly at the store end, and a wide image
        // with the largest stride drives the index far beyond it.
        load_geometry(2, 64, 64, 1, 1, 1, 1, 1);
        read_columns(2);
        load_geometry(2, 127, 127, 1, 1, 1, 2, 15);
        read_columns(4);
        // Shrink the column bound while the scan sits beyond it.
        load_geometry(1, 8, 8, 1, 1, 1, 8, 1);
        read_columns(5);
        load_geometry(1, 8, 8, 1, 1, 1, 3, 1);
        read_columns(2);
        // Bounds above the counter range saturate; stride zero repeats windows.
        load_geometry(127, 64, 64, 31, 31, 127, 2, 0);
        read_columns(3);

        for (int p = 0; p < PHASES; p++) begin
            rewind_scan();
            case (p)
                0: load_geometry(1, 1, 1, 1, 1, 1, 1, 1);
                1: load_geometry(127, 127, 127, 31, 31, 127, 127, 15);
                2: load_geometry(64, 64, 64, 16, 16, 64, 64, 8);
                default: load_geometry(7'($urandom_range(1, 2)), 7'($urandom_range(2, 10)),
                                       7'($urandom_range(2, 10)), 7'($urandom_range(0, 2)),
                                       7'($urandom_range(1, 3)), 7'($urandom_range(1, 3)),
                                       7'($urandom_range(1, 4)), 7'($urandom_range(0, 3)));
            endcase
            steady = (p == 5);
            repeat (PHASE_BEATS) random_beat();
        end
        steady = 1'b0;

        s_valid <= 1'b0;
        drain = 0;
        while (pending_count != 0 && drain < DRAIN_CYCLES) begin
            @(negedge aclk);
            drain++;
        end
        if (pending_count != 0) begin
            $display("Column results still outstanding: %0d", pending_count);
            $display("Test completed with failures");
            $finish;
        end else begin
            repeat (10) @(negedge aclk);
            $display("Sent %0d beats over %0d register settings; checked %0d columns.",
                     beats_sent, settings_loaded, columns_checked);
            $display("Saw %0d matrix ends and %0d reads beyond the store.",
                     last_count, oor_count);
            if (fail_count == 0) begin
                $display("Test completed successfully");
            end else begin
                $display("Test completed with failures");
            end
            $finish;
        end
    end

    initial begin
        #3ms;
        $display("Run stopped by the time limit.");
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ----- im2col_column_reorder.f -----
rtl/imcol_pkg.sv
rtl/imcol_ctrl.sv
rtl/imcol_dp.sv
rtl/im2col_column_reorder.sv
test/im2col_column_checker.sv
test/im2col_column_reorder_tb.sv
